// ===== rtl/core/pfps_pkg.sv =====
// ----------------------------------------------------------------------------
// pfps_pkg
// Shared types, pattern table and helpers of the page feature pattern scanner.
// ----------------------------------------------------------------------------
package pfps_pkg;

  // Table geometry
  localparam int PAT_COUNT      = 28;
  localparam int PAT_MAX_LEN    = 20;
  localparam int RULE_COUNT     = 15;
  localparam int RULE_IDX_W     = $clog2(RULE_COUNT);
  localparam int DEF_WINDOW_LEN = 20;

  typedef logic [7:0]               byte_t;
  typedef logic [PAT_MAX_LEN*8-1:0] pat_text_t;
  typedef logic [RULE_COUNT-1:0]    rule_vec_t;
  typedef logic [RULE_IDX_W-1:0]    rule_idx_t;

  // Control to every window cell
  typedef struct packed {
    logic shift;  // take the neighbor's byte
    logic clear;  // zero the byte (end of document)
  } cell_ctrl_t;

  // Lower-case patterns, last character in bits [7:0]
  localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
    pat_text_t'("<script"),
    pat_text_t'("type=\"module\""),
    pat_text_t'("type='module'"),
    pat_text_t'("import("),
    pat_text_t'("createapp("),
    pat_text_t'("createssrapp("),
    pat_text_t'(56'h5f5f70696e6961),  // store marker with double underscore
    pat_text_t'("data-v-"),
    pat_text_t'("fetch("),
    pat_text_t'("xmlhttprequest"),
    pat_text_t'("intersectionobserver"),
    pat_text_t'("resizeobserver"),
    pat_text_t'("mutationobserver"),
    pat_text_t'("<canvas"),
    pat_text_t'("<svg"),
    pat_text_t'("webassembly"),
    pat_text_t'("new worker("),
    pat_text_t'("sharedworker("),
    pat_text_t'("mediasource"),
    pat_text_t'("sourcebuffer"),
    pat_text_t'("<audio"),
    pat_text_t'("audiocontext"),
    pat_text_t'("<video"),
    pat_text_t'("webgl"),
    pat_text_t'("websocket"),
    pat_text_t'("localstorage"),
    pat_text_t'("sessionstorage"),
    pat_text_t'("indexeddb")
  };

  localparam int PAT_LEN [PAT_COUNT] = '{
    7, 13, 13, 7, 10, 13, 7, 7, 6, 14, 20, 14, 16, 7,
    4, 11, 11, 13, 11, 12, 6, 12, 6, 5, 9, 12, 14, 9
  };

  localparam rule_idx_t PAT_RULE [PAT_COUNT] = '{
    4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9,
    4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd14, 4'd14
  };

  // ASCII capitals to lower case, everything else unchanged
  function automatic byte_t fold_byte(input byte_t b);
    if (b >= 8'h41 && b <= 8'h5a) begin
      return b + 8'h20;
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/page_feature_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// page_feature_pattern_scanner
// Case-insensitive multi-pattern scanner over a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, every cycle, while the result register
// is free or being drained. Bytes are folded to lower case and shifted into a
// row of WINDOW_LEN-1 byte cells; the incoming byte together with the cells
// is compared against 28 fixed patterns in the same cycle, and each match sets
// a sticky rule flag. The transfer of a byte marked document_end loads the
// 15-bit rule vector into the output register and clears the cells and
// flags, so the next document may start in the very next cycle.
// The only stall is a waiting result that is not taken.
module page_feature_pattern_scanner #(
  parameter int WINDOW_LEN = pfps_pkg::DEF_WINDOW_LEN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfps_pkg::byte_t     in_data_byte,
  input  logic                in_document_end,
  output logic                out_valid,
  input  logic                out_ready,
  output pfps_pkg::rule_vec_t out_rule_hits
);
  import pfps_pkg::*;

  logic       in_xfer;
  cell_ctrl_t cell_ctrl;
  byte_t      taps   [WINDOW_LEN];
  byte_t      cell_q [WINDOW_LEN-1];
  rule_vec_t  match_hits;
  rule_vec_t  hits_all;

  rule_vec_t  sticky_r,    sticky_nxt;
  logic       out_valid_r, out_valid_nxt;
  rule_vec_t  out_hits_r,  out_hits_nxt;

  // Input handshake: free unless a result waits and is not taken
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;

  assign cell_ctrl.shift = in_xfer;
  assign cell_ctrl.clear = in_document_end;

  // Taps: folded new byte, then the stored bytes
  always_comb begin
    taps[0] = fold_byte(in_data_byte);
    for (int j = 1; j < WINDOW_LEN; j++) begin
      taps[j] = cell_q[j-1];
    end
  end

  // Row of window cells; the oldest tap is never needed again after a shift
  for (genvar g = 0; g < WINDOW_LEN - 1; g++) begin : g_cell
    pfps_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (cell_ctrl),
      .d_in  (taps[g]),
      .q     (cell_q[g])
    );
  end

  pfps_match #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_match (
    .taps (taps),
    .hits (match_hits)
  );

  assign hits_all = sticky_r | match_hits;

  // Sticky flags and result register
  always_comb begin
    sticky_nxt    = sticky_r;
    out_valid_nxt = out_valid_r;
    out_hits_nxt  = out_hits_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      if (in_document_end) begin
        sticky_nxt    = '0;
        out_valid_nxt = 1'b1;
        out_hits_nxt  = hits_all;
      end else begin
        sticky_nxt = hits_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sticky_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hits_r <= out_hits_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_rule_hits = out_hits_r;

endmodule

// ===== rtl/core/pfps_cell.sv =====
// ----------------------------------------------------------------------------
// pfps_cell
// One byte of the history window; takes its neighbor's byte on each transfer, or zero at a document end.
// ----------------------------------------------------------------------------
module pfps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pfps_pkg::cell_ctrl_t ctrl,
  input  pfps_pkg::byte_t     d_in,
  output pfps_pkg::byte_t     q
);
  import pfps_pkg::*;

  byte_t q_r;
  byte_t q_nxt;

  // Shift or clear
  always_comb begin
    q_nxt = q_r;
    if (ctrl.shift) begin
      q_nxt = ctrl.clear ? '0 : d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/core/pfps_match.sv =====
// ----------------------------------------------------------------------------
// pfps_match
// Compares the window taps against every pattern; a pattern hits when it
// ends on the newest byte. Hits are merged per rule.
// ----------------------------------------------------------------------------
module pfps_match #(
  parameter int WINDOW_LEN = pfps_pkg::DEF_WINDOW_LEN
) (
  input  pfps_pkg::byte_t     taps [WINDOW_LEN],
  output pfps_pkg::rule_vec_t hits
);
  import pfps_pkg::*;

  // Each pattern checked independently, newest byte at tap 0
  always_comb begin
    logic hit;
    hits = '0;
    for (int k = 0; k < PAT_COUNT; k++) begin
      hit = (PAT_LEN[k] <= WINDOW_LEN);
      for (int j = 0; j < PAT_MAX_LEN; j++) begin
        if (j < PAT_LEN[k] && j < WINDOW_LEN) begin
          if (taps[j] != PAT_TEXT[k][8*j +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        hits[PAT_RULE[k]] = 1'b1;
      end
    end
  end

endmodule

// ===== sim/page_feature_pattern_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_feature_pattern_scanner_tb
// Self-checking bench for the case-insensitive document pattern scanner.
// ----------------------------------------------------------------------------
// Documents are streamed one byte per transfer. A short table of documents
// exercises every pattern, mixed case, non-ASCII bytes, zero bytes, near
// misses and a pattern split across two documents. Random documents follow,
// built mostly from whole or cut-off patterns in random case, mixed with
// noise bytes. A local scanner model keeps its own window and rule flags and
// predicts the rule vector of every document without a table answer. The
// sender works in bursts, the receiver stalls on its own schedule, and one
// long receiver hold-off forces back-pressure onto the input.
module page_feature_pattern_scanner_tb;
  import pfps_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int SCAN_DEPTH   = DEF_WINDOW_LEN;
  localparam int KW_COUNT     = 28;
  localparam int DOC_ROWS     = 25;
  localparam int RANDOM_BYTES = 250;
  localparam int RANDOM_DOCS  = 10;
  localparam int HOLD_START   = 300;
  localparam int HOLD_LEN     = 400;
  localparam int WATCHDOG     = 1500;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;

  typedef logic [SCAN_DEPTH*8-1:0] kw_text_t;

  typedef struct packed {
    byte_t     data;
    logic      last;
    logic      typed;  // hits below is the known answer for this document
    rule_vec_t hits;
  } scan_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_t;

  // Keywords in lower case, last character in the low byte
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    "<script",
    "type=\"module\"", "type='module'", "import(",
    "createapp(", "createssrapp(", 56'h5f5f70696e6961, "data-v-",
    "fetch(", "xmlhttprequest",
    "intersectionobserver", "resizeobserver", "mutationobserver",
    "<canvas",
    "<svg",
    "webassembly",
    "new worker(", "sharedworker(",
    "mediasource", "sourcebuffer",
    "<audio", "audiocontext",
    "<video",
    "webgl",
    "websocket",
    "localstorage", "sessionstorage", "indexeddb"
  };

  localparam int KW_RULE [KW_COUNT] = '{
    0, 1, 1, 1, 2, 2, 2, 2, 3, 3, 4, 4, 4, 5,
    6, 7, 8, 8, 9, 9, 10, 10, 11, 12, 13, 14, 14, 14
  };

  // Directed documents; hits of -1 leaves the answer to the local model
  string doc_text [DOC_ROWS] = '{
    "",                                        // lone zero byte
    "<SCRIPT>",
    "Type=\"Module\" TYPE='module' import(x)",
    "createApp( createSSRApp(",
    "__\120\111\116\111\101",                  // store marker, upper case
    "<div data-v-7a>",
    "fetch(url) XMLHttpRequest",
    "IntersectionObserver",                    // fills the whole window
    "ResizeObserver mutationobserver",
    "<Canvas",
    "\377\200<svg\341",
    "WebAssembly",
    "new Worker( SharedWorker(",
    "MediaSource sourceBuffer",
    "<audio AudioContext",
    "<VIDEO",
    "webgl",
    "WebSocket",
    "localStorage sessionStorage indexedDB",
    "intersectionobserve",                     // one short
    "<scri",                                   // split across documents
    "pt",
    "webgl",                                   // zero byte inside
    {"<script import( data-v- fetch( resizeobserver <canvas <svg webassembly ",
     "new worker( mediasource <audio <video webgl websocket indexeddb"},
    "\177[@{\140Z xMLhTTPrEQUEST"
  };
  int doc_zero_at [DOC_ROWS] = '{
    0, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
    -1, -1, -1, -1, -1, -1, -1, -1, -1, 3, -1, -1
  };
  int doc_hits [DOC_ROWS] = '{
    'h0000, 'h0001, 'h0002, 'h0004, 'h0004, 'h0004, 'h0008, 'h0010, 'h0010,
    'h0020, 'h0040, 'h0080, 'h0100, 'h0200, 'h0400, 'h0800, 'h1000, 'h2000,
    'h4000, 'h0000, 'h0000, 'h0000, 'h0000, 'h7fff, -1
  };

  logic      clk             = 1'b0;
  logic      rst_n           = 1'b0;
  logic      in_valid        = 1'b0;
  logic      in_ready;
  byte_t     in_data_byte    = '0;
  logic      in_document_end = 1'b0;
  logic      out_valid;
  logic      out_ready       = 1'b0;
  rule_vec_t out_rule_hits;

  scan_item_t stim_q [$];
  rule_vec_t  pending_rule_vectors [$];

  // Local scanner model state
  byte_t     scan_window [SCAN_DEPTH];
  rule_vec_t sticky_rules;

  int        accepted_bytes = 0;
  int        checked_docs   = 0;
  int        doc_count      = 0;
  int        error_count    = 0;
  int        stall_cycles   = 0;
  rule_vec_t rules_seen     = '0;
  rule_vec_t predicted_hits;
  rule_vec_t wanted_hits;

  int        rx_cycle  = 0;
  int        hold_left = 0;
  rx_mode_t  rx_mode   = RX_OPEN;

  page_feature_pattern_scanner dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_document_end(in_document_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rule_hits  (out_rule_hits)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Keyword length: count of non-zero bytes from the low end
  function automatic int kw_len(input int k);
    int n;
    n = 0;
    for (int j = 0; j < SCAN_DEPTH; j++) begin
      if (KW_TEXT[k][8*j +: 8] != 8'h00) n = j + 1;
    end
    return n;
  endfunction

  // Shift one byte into the model; returns 1 and the rule vector on a last byte
  function automatic logic scan_byte(input byte_t raw, input logic last,
                                     output rule_vec_t hits);
    byte_t low;
    int    len;
    logic  match;
    low = (raw >= 8'h41 && raw <= 8'h5a) ? byte_t'(raw + 8'h20) : raw;
    for (int j = SCAN_DEPTH - 1; j > 0; j--) scan_window[j] = scan_window[j-1];
    scan_window[0] = low;
    for (int k = 0; k < KW_COUNT; k++) begin
      len   = kw_len(k);
      match = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (scan_window[j] != KW_TEXT[k][8*j +: 8]) match = 1'b0;
      end
      if (match) sticky_rules[KW_RULE[k]] = 1'b1;
    end
    hits = sticky_rules;
    if (last) begin
      foreach (scan_window[j]) scan_window[j] = 8'h00;
      sticky_rules = '0;
    end
    return last;
  endfunction

  function automatic void add_byte(input byte_t b, input logic last, input int known);
    scan_item_t it;
    it.data  = b;
    it.last  = last;
    it.typed = (known >= 0);
    it.hits  = rule_vec_t'(known);
    stim_q.push_back(it);
  endfunction

  // Random document: mostly whole or cut-off keywords in random case, some noise
  function automatic void add_random_doc();
    byte_t doc [$];
    byte_t c;
    int    kind;
    int    k;
    int    cut;
    int    len;
    int    cmode;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 24)) doc.push_back(byte_t'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          k     = $urandom_range(0, KW_COUNT - 1);
          len   = kw_len(k);
          cut   = (kind >= 5) ? $urandom_range(1, len - 1) : len;
          cmode = $urandom_range(0, 2);
          for (int j = 0; j < cut; j++) begin
            c = KW_TEXT[k][8*(len-1-j) +: 8];
            if (c >= 8'h61 && c <= 8'h7a &&
                (cmode == 1 || (cmode == 2 && $urandom_range(0, 1) == 1))) begin
              c = c - 8'h20;
            end
            doc.push_back(c);
          end
        end else begin
          repeat ($urandom_range(1, 5)) doc.push_back(byte_t'($urandom));
        end
      end
    end
    for (int j = 0; j < doc.size(); j++) add_byte(doc[j], j == doc.size() - 1, -1);
  endfunction

  // Receiver: stalls in a randomly chosen mode, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle == HOLD_START) hold_left = HOLD_LEN;
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:    out_ready <= 1'b1;
          RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
          RX_CADENCE: out_ready <= (rx_cycle % 5) >= 3;
          default:    out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Transfer monitor, result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accepted_bytes = accepted_bytes + 1;
        if (scan_byte(in_data_byte, in_document_end, predicted_hits)) begin
          if (stim_q[accepted_bytes-1].typed) begin
            pending_rule_vectors.push_back(stim_q[accepted_bytes-1].hits);
          end else begin
            pending_rule_vectors.push_back(predicted_hits);
          end
        end
      end
      if (out_valid && out_ready) begin
        checked_docs = checked_docs + 1;
        rules_seen   = rules_seen | out_rule_hits;
        if (pending_rule_vectors.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t: unexpected result, expected none actual rule_hits=%h",
                   $time, out_rule_hits);
        end else begin
          wanted_hits = pending_rule_vectors.pop_front();
          if (out_rule_hits !== wanted_hits) begin
            error_count = error_count + 1;
            $display("%0t: rule_hits mismatch, expected %h actual %h",
                     $time, wanted_hits, out_rule_hits);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
          $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
          $display("page_feature_pattern_scanner_tb failed");
          $finish;
        end
      end
    end
  end

  // Stimulus, sender and end of run
  initial begin
    int n;
    int n_directed;
    int pause_a;
    int pause_b;
    int burst_left;
    int gap;
    int drain;

    foreach (scan_window[j]) scan_window[j] = 8'h00;
    sticky_rules = '0;

    // Directed table; a zero byte may be inserted before a given position
    for (int r = 0; r < DOC_ROWS; r++) begin
      n = doc_text[r].len();
      for (int j = 0; j <= n; j++) begin
        if (j == doc_zero_at[r]) add_byte(8'h00, j == n, doc_hits[r]);
        if (j < n) begin
          add_byte(doc_text[r][j], j == n - 1 && doc_zero_at[r] != n, doc_hits[r]);
        end
      end
      doc_count = doc_count + 1;
    end
    n_directed = stim_q.size();

    while (stim_q.size() - n_directed < RANDOM_BYTES ||
           doc_count - DOC_ROWS < RANDOM_DOCS) begin
      add_random_doc();
      doc_count = doc_count + 1;
    end
    pause_a    = n_directed;
    pause_b    = n_directed + (stim_q.size() - n_directed) / 2;
    burst_left = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == pause_a || i == pause_b) begin
        // sender waits for every outstanding rule vector
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_rule_vectors.size() != 0);
        @(posedge clk);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (burst_left != 0) burst_left = burst_left - 1;
      in_valid        <= 1'b1;
      in_data_byte    <= stim_q[i].data;
      in_document_end <= stim_q[i].last;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;

    // drain, then wait for stray results
    drain = 0;
    while (pending_rule_vectors.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain = drain + 1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rule_vectors.size() != 0) begin
      error_count = error_count + 1;
      $display("%0t: %0d rule vectors never arrived", $time, pending_rule_vectors.size());
    end

    $display("Streamed %0d bytes in %0d documents, %0d rule vectors checked.",
             accepted_bytes, doc_count, checked_docs);
    $display("Union of rule bits reported: %h, errors: %0d", rules_seen, error_count);
    if (error_count == 0) begin
      $display("page_feature_pattern_scanner_tb passed");
    end else begin
      $display("page_feature_pattern_scanner_tb failed");
    end
    $finish;
  end

endmodule
